[sv/mst_pkg.sv]
// Shared constants, field widths and helpers for the max segment tree.
package mst_pkg;

    // Default number of leaves
    localparam int unsigned LEAVES_DEF = 1024;

    // Field widths of the input and result transactions
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned POS_W   = 10;
    localparam int unsigned RANGE_W = 11;

    // Transaction kinds
    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // Unsigned maximum of two node words
    function automatic logic [VALUE_W-1:0] max_word(
        input logic [VALUE_W-1:0] a,
        input logic [VALUE_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

endpackage

[sv/max_segment_tree.sv]
// Bottom-up maximum segment tree with a shared node memory and a small sequencer.
//
// Range-maximum segment tree over LEAVES unsigned 64-bit leaves, kept in one
// node memory of 2*LEAVES words (one write port, two registered read ports).
// After reset the block clears every word of the memory to zero with s_ready
// low. An update (s_kind = 0) writes its leaf in the accept cycle and then, for
// each ancestor, reads both children and writes their maximum; it gives no
// result. An update with s_position >= LEAVES is dropped. A query (s_kind = 1)
// climbs the tree one level per node read pair and accumulate step, then
// closes out. Its maximum leaves on the m_ channel; bounds above LEAVES are
// clamped to LEAVES and an empty or reversed range returns 0. One transaction
// is in flight at a time; the next is accepted while a query result still
// waits on m_ready, as long as that result has been moved to the output
// register.
module max_segment_tree #(
    parameter int unsigned LEAVES = mst_pkg::LEAVES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input transaction channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_kind,
    input  logic [mst_pkg::POS_W-1:0]    s_position,
    input  logic [mst_pkg::VALUE_W-1:0]  s_value,
    input  logic [mst_pkg::RANGE_W-1:0]  s_range_begin,
    input  logic [mst_pkg::RANGE_W-1:0]  s_range_end,
    // Result transaction channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [mst_pkg::VALUE_W-1:0]  m_max_value
);
    import mst_pkg::*;

    localparam int unsigned NODES  = 2 * LEAVES;
    localparam int unsigned IDX_W  = $clog2(NODES);
    localparam int unsigned BND_W  = IDX_W + 1;
    localparam logic [31:0] LEAVES32 = 32'(LEAVES);
    localparam logic [IDX_W-1:0] LAST_NODE = IDX_W'(NODES - 1);

    typedef enum logic [6:0] {
        S_CLR   = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_UP_RD = 7'b0000100,
        S_UP_WR = 7'b0001000,
        S_Q_RD  = 7'b0010000,
        S_Q_ACC = 7'b0100000,
        S_Q_OUT = 7'b1000000
    } state_t;

    // Node memory and its registered read data
    logic [VALUE_W-1:0] node_mem [0:NODES-1];
    logic [VALUE_W-1:0] rd_a_reg;
    logic [VALUE_W-1:0] rd_b_reg;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    // lo_reg doubles as the ancestor pointer during an update
    logic [BND_W-1:0]   lo_reg, lo_next;
    logic [BND_W-1:0]   hi_reg, hi_next;
    logic [VALUE_W-1:0] acc_l_reg, acc_l_next;
    logic [VALUE_W-1:0] acc_r_reg, acc_r_next;
    logic               m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0] m_max_reg, m_max_next;

    // Memory port controls
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr_a;
    logic [IDX_W-1:0]   mem_raddr_b;

    // Accept-time decode of the input fields
    logic [31:0]        pos32;
    logic [31:0]        beg32;
    logic [31:0]        end32;
    logic [31:0]        beg_sat;
    logic [31:0]        end_sat;
    logic [IDX_W-1:0]   leaf_addr;
    logic               accept;
    logic               out_free;

    assign s_ready     = (state_reg == S_IDLE);
    assign accept      = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_max_value = m_max_reg;
    assign out_free    = !m_valid_reg || m_ready;

    assign pos32     = 32'(s_position);
    assign beg32     = 32'(s_range_begin);
    assign end32     = 32'(s_range_end);
    assign beg_sat   = (beg32 > LEAVES32) ? LEAVES32 : beg32;
    assign end_sat   = (end32 > LEAVES32) ? LEAVES32 : end32;
    assign leaf_addr = IDX_W'(pos32 + LEAVES32);

    // Address of the node just left of the right bound
    function automatic logic [IDX_W-1:0] hi_next_dec(input logic [BND_W-1:0] hi);
        logic [BND_W-1:0] dec;
        dec = hi - 1'b1;
        return dec[IDX_W-1:0];
    endfunction

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        acc_l_next   = acc_l_reg;
        acc_r_next   = acc_r_reg;
        m_valid_next = m_valid_reg;
        m_max_next   = m_max_reg;
        mem_we       = 1'b0;
        mem_waddr    = clr_reg;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr_a  = lo_reg[IDX_W-1:0];
        mem_raddr_b  = hi_reg[IDX_W-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_NODE) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (s_kind == KIND_UPDATE) begin
                        if (pos32 < LEAVES32) begin
                            mem_we     = 1'b1;
                            mem_waddr  = leaf_addr;
                            mem_wdata  = s_value;
                            lo_next    = BND_W'(leaf_addr >> 1);
                            state_next = S_UP_RD;
                        end
                    end else begin
                        lo_next    = BND_W'(beg_sat + LEAVES32);
                        hi_next    = BND_W'(end_sat + LEAVES32);
                        acc_l_next = '0;
                        acc_r_next = '0;
                        state_next = S_Q_RD;
                    end
                end
            end
            // Fetch both children of the current ancestor
            S_UP_RD: begin
                mem_re      = 1'b1;
                mem_raddr_a = {lo_reg[IDX_W-2:0], 1'b0};
                mem_raddr_b = {lo_reg[IDX_W-2:0], 1'b1};
                state_next  = S_UP_WR;
            end
            // Write the larger child and climb
            S_UP_WR: begin
                mem_we    = 1'b1;
                mem_waddr = lo_reg[IDX_W-1:0];
                mem_wdata = max_word(rd_a_reg, rd_b_reg);
                lo_next   = lo_reg >> 1;
                if ((lo_reg >> 1) == '0) begin
                    state_next = S_IDLE;
                end else begin
                    state_next = S_UP_RD;
                end
            end
            // Read the left bound node and the node just below the right bound
            S_Q_RD: begin
                if (lo_reg < hi_reg) begin
                    mem_re      = 1'b1;
                    mem_raddr_a = lo_reg[IDX_W-1:0];
                    mem_raddr_b = hi_next_dec(hi_reg);
                    state_next  = S_Q_ACC;
                end else begin
                    state_next = S_Q_OUT;
                end
            end
            // Fold in odd bounds, then move both bounds up one level
            S_Q_ACC: begin
                if (lo_reg[0]) begin
                    acc_l_next = max_word(acc_l_reg, rd_a_reg);
                end
                if (hi_reg[0]) begin
                    acc_r_next = max_word(rd_b_reg, acc_r_reg);
                end
                lo_next    = (lo_reg + BND_W'(lo_reg[0])) >> 1;
                hi_next    = hi_reg >> 1;
                state_next = S_Q_RD;
            end
            // Hand the result to the output register once it is free
            S_Q_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_max_next   = max_word(acc_l_reg, acc_r_reg);
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLR;
            end
        endcase
    end

    // Node memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_a_reg <= node_mem[mem_raddr_a];
            rd_b_reg <= node_mem[mem_raddr_b];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        acc_l_reg <= acc_l_next;
        acc_r_reg <= acc_r_next;
        m_max_reg <= m_max_next;
    end

    // A result only appears after the close-out step of a query
    a_result_from_query: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_Q_OUT))
        else $error("result raised outside query close-out");

    // The update walk never writes the unused node zero
    a_no_node_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UP_WR) |-> (lo_reg != '0))
        else $error("update walk reached node zero");

    // Each accumulate step halves the right bound and goes back to read
    a_query_climb: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_Q_ACC) |=> (state_reg == S_Q_RD) && (hi_reg == ($past(hi_reg) >> 1)))
        else $error("query bound did not climb");

    // No result can be pending while the memory is still being cleared
    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLR) |-> !m_valid_reg)
        else $error("result pending during clear");

endmodule
